// File: hdl/tks_pkg.sv
package tks_pkg;

  localparam int unsigned MaxVertices = 64;
  localparam int unsigned MaxEdges    = 256;

  localparam int unsigned VtxW  = $clog2(MaxVertices);
  localparam int unsigned CntW  = VtxW + 1;
  localparam int unsigned EdgeW = $clog2(MaxEdges);
  localparam int unsigned EcntW = EdgeW + 1;
  localparam int unsigned DegW  = EcntW;

  localparam logic [CntW-1:0] VtxCountReset = CntW'(MaxVertices);

endpackage

// File: hdl/tks_ram.sv
module tks_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 64
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/topological_sort_kahn.sv
// Edge load requests are taken in the idle state; the block is ready again the next cycle.
// A sort request first clears all MaxVertices in-degree entries, then counts in-degrees over
// the stored edges, then seeds the queue with the vertices of zero in-degree, then for each
// emitted vertex scans the whole edge store through its single read port.
// Results follow as the output register drains.
// Reset (rst_ni low, asynchronous) empties the edge store and sets vertex_count to 64.
module topological_sort_kahn (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [tks_pkg::CntW-1:0]   cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       mode_i,
  input  logic [tks_pkg::VtxW-1:0]   src_vertex_i,
  input  logic [tks_pkg::VtxW-1:0]   dst_vertex_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [tks_pkg::VtxW-1:0]   vertex_out_o,
  output logic                       vertex_valid_o,
  output logic                       cycle_found_o,
  output logic                       edge_dropped_o,
  output logic                       last_result_o
);

  localparam int unsigned VW = tks_pkg::VtxW;
  localparam int unsigned CW = tks_pkg::CntW;
  localparam int unsigned EW = tks_pkg::EdgeW;
  localparam int unsigned NW = tks_pkg::EcntW;
  localparam int unsigned DW = tks_pkg::DegW;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLR    = 4'd1;
  localparam logic [3:0] S_CNT_RD = 4'd2;
  localparam logic [3:0] S_CNT_E  = 4'd3;
  localparam logic [3:0] S_CNT_D  = 4'd4;
  localparam logic [3:0] S_ZQ_RD  = 4'd5;
  localparam logic [3:0] S_ZQ_D   = 4'd6;
  localparam logic [3:0] S_POP_RD = 4'd7;
  localparam logic [3:0] S_POP_D  = 4'd8;
  localparam logic [3:0] S_POP_EM = 4'd9;
  localparam logic [3:0] S_SCN_RD = 4'd10;
  localparam logic [3:0] S_SCN_E  = 4'd11;
  localparam logic [3:0] S_SCN_D  = 4'd12;
  localparam logic [3:0] S_FIN    = 4'd13;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] vcount_q;
  logic [NW-1:0] ecnt_q, ecnt_d;
  logic          drop_q, drop_d;
  logic [NW-1:0] eidx_q, eidx_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] rpos_q, rpos_d;
  logic [CW-1:0] wpos_q, wpos_d;
  logic [VW-1:0] cur_q, cur_d;
  logic [VW-1:0] tgt_q, tgt_d;
  logic          hold_vld_q, hold_vld_d;
  logic [VW-1:0] hold_vtx_q, hold_vtx_d;

  logic          out_vld_q, out_vld_d;
  logic [VW-1:0] out_vtx_q, out_vtx_d;
  logic          out_vv_q, out_vv_d;
  logic          out_cyc_q, out_cyc_d;
  logic          out_drp_q, out_drp_d;
  logic          out_last_q, out_last_d;

  // Edge store: source in the upper bits, target in the lower bits.
  logic            e_we;
  logic [EW-1:0]   e_waddr, e_raddr;
  logic [2*VW-1:0] e_wdata, e_rdata;
  // In-degree store.
  logic            d_we;
  logic [VW-1:0]   d_waddr, d_raddr;
  logic [DW-1:0]   d_wdata, d_rdata;
  // Ready queue.
  logic            q_we;
  logic [VW-1:0]   q_waddr, q_raddr;
  logic [VW-1:0]   q_wdata, q_rdata;

  logic [CW-1:0] n_act;
  logic [VW-1:0] e_src, e_tgt;
  logic          can_push;
  logic          in_acc;

  tks_ram #(.W(2 * VW), .D(tks_pkg::MaxEdges)) u_edge_ram (
    .clk_i  (clk_i),
    .we_i   (e_we),
    .waddr_i(e_waddr),
    .wdata_i(e_wdata),
    .raddr_i(e_raddr),
    .rdata_o(e_rdata)
  );

  tks_ram #(.W(DW), .D(tks_pkg::MaxVertices)) u_deg_ram (
    .clk_i  (clk_i),
    .we_i   (d_we),
    .waddr_i(d_waddr),
    .wdata_i(d_wdata),
    .raddr_i(d_raddr),
    .rdata_o(d_rdata)
  );

  tks_ram #(.W(VW), .D(tks_pkg::MaxVertices)) u_queue_ram (
    .clk_i  (clk_i),
    .we_i   (q_we),
    .waddr_i(q_waddr),
    .wdata_i(q_wdata),
    .raddr_i(q_raddr),
    .rdata_o(q_rdata)
  );

  // The effective vertex count saturates at the store size.
  assign n_act = (vcount_q > CW'(tks_pkg::MaxVertices)) ? CW'(tks_pkg::MaxVertices)
                                                         : vcount_q;
  assign e_src = e_rdata[2*VW-1:VW];
  assign e_tgt = e_rdata[VW-1:0];

  // The output register can take a new result when it is empty or being drained.
  assign can_push    = !out_vld_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d    = state_q;
    ecnt_d     = ecnt_q;
    drop_d     = drop_q;
    eidx_d     = eidx_q;
    idx_d      = idx_q;
    rpos_d     = rpos_q;
    wpos_d     = wpos_q;
    cur_d      = cur_q;
    tgt_d      = tgt_q;
    hold_vld_d = hold_vld_q;
    hold_vtx_d = hold_vtx_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    out_vtx_d  = out_vtx_q;
    out_vv_d   = out_vv_q;
    out_cyc_d  = out_cyc_q;
    out_drp_d  = out_drp_q;
    out_last_d = out_last_q;

    e_we    = 1'b0;
    e_waddr = ecnt_q[EW-1:0];
    e_wdata = {src_vertex_i, dst_vertex_i};
    e_raddr = eidx_q[EW-1:0];
    d_we    = 1'b0;
    d_waddr = idx_q[VW-1:0];
    d_wdata = '0;
    d_raddr = idx_q[VW-1:0];
    q_we    = 1'b0;
    q_waddr = wpos_q[VW-1:0];
    q_wdata = idx_q[VW-1:0];
    q_raddr = rpos_q[VW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (mode_i) begin
            idx_d   = '0;
            rpos_d  = '0;
            wpos_d  = '0;
            hold_vld_d = 1'b0;
            state_d = S_CLR;
          end else if (({1'b0, src_vertex_i} >= n_act) || ({1'b0, dst_vertex_i} >= n_act) ||
                       ecnt_q[NW-1]) begin
            drop_d = 1'b1;
          end else begin
            e_we   = 1'b1;
            ecnt_d = ecnt_q + NW'(1);
          end
        end
      end
      S_CLR: begin
        d_we  = 1'b1;
        idx_d = idx_q + CW'(1);
        if (idx_q == CW'(tks_pkg::MaxVertices - 1)) begin
          idx_d  = '0;
          eidx_d = '0;
          state_d = (ecnt_q == '0) ? S_ZQ_RD : S_CNT_RD;
        end
      end
      S_CNT_RD: begin
        state_d = S_CNT_E;
      end
      S_CNT_E: begin
        if (({1'b0, e_src} < n_act) && ({1'b0, e_tgt} < n_act)) begin
          d_raddr = e_tgt;
          tgt_d   = e_tgt;
          state_d = S_CNT_D;
        end else begin
          eidx_d  = eidx_q + NW'(1);
          state_d = (eidx_q + NW'(1) == ecnt_q) ? S_ZQ_RD : S_CNT_RD;
        end
      end
      S_CNT_D: begin
        d_we    = 1'b1;
        d_waddr = tgt_q;
        d_wdata = d_rdata + DW'(1);
        eidx_d  = eidx_q + NW'(1);
        state_d = (eidx_q + NW'(1) == ecnt_q) ? S_ZQ_RD : S_CNT_RD;
      end
      S_ZQ_RD: begin
        state_d = (idx_q == n_act) ? S_POP_RD : S_ZQ_D;
      end
      S_ZQ_D: begin
        if (d_rdata == '0) begin
          q_we   = 1'b1;
          wpos_d = wpos_q + CW'(1);
        end
        idx_d   = idx_q + CW'(1);
        state_d = S_ZQ_RD;
      end
      S_POP_RD: begin
        if (rpos_q == wpos_q) begin
          state_d = S_FIN;
        end else begin
          rpos_d  = rpos_q + CW'(1);
          state_d = S_POP_D;
        end
      end
      S_POP_D: begin
        cur_d   = q_rdata;
        state_d = S_POP_EM;
      end
      S_POP_EM: begin
        if (!hold_vld_q || can_push) begin
          if (hold_vld_q) begin
            out_vld_d  = 1'b1;
            out_vtx_d  = hold_vtx_q;
            out_vv_d   = 1'b1;
            out_cyc_d  = 1'b0;
            out_drp_d  = 1'b0;
            out_last_d = 1'b0;
          end
          hold_vld_d = 1'b1;
          hold_vtx_d = cur_q;
          eidx_d     = ecnt_q - NW'(1);
          state_d    = (ecnt_q == '0) ? S_POP_RD : S_SCN_RD;
        end
      end
      S_SCN_RD: begin
        state_d = S_SCN_E;
      end
      S_SCN_E: begin
        if ((e_src == cur_q) && ({1'b0, e_tgt} < n_act)) begin
          d_raddr = e_tgt;
          tgt_d   = e_tgt;
          state_d = S_SCN_D;
        end else begin
          eidx_d  = eidx_q - NW'(1);
          state_d = (eidx_q == '0) ? S_POP_RD : S_SCN_RD;
        end
      end
      S_SCN_D: begin
        if (d_rdata != '0) begin
          d_we    = 1'b1;
          d_waddr = tgt_q;
          d_wdata = d_rdata - DW'(1);
          if (d_rdata == DW'(1)) begin
            q_we    = 1'b1;
            q_wdata = tgt_q;
            wpos_d  = wpos_q + CW'(1);
          end
        end
        eidx_d  = eidx_q - NW'(1);
        state_d = (eidx_q == '0) ? S_POP_RD : S_SCN_RD;
      end
      S_FIN: begin
        if (can_push) begin
          out_vld_d  = 1'b1;
          out_vtx_d  = hold_vld_q ? hold_vtx_q : '0;
          out_vv_d   = hold_vld_q;
          out_cyc_d  = (rpos_q != n_act);
          out_drp_d  = drop_q;
          out_last_d = 1'b1;
          hold_vld_d = 1'b0;
          ecnt_d     = '0;
          drop_d     = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      vcount_q   <= tks_pkg::VtxCountReset;
      ecnt_q     <= '0;
      drop_q     <= 1'b0;
      eidx_q     <= '0;
      idx_q      <= '0;
      rpos_q     <= '0;
      wpos_q     <= '0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      if (cfg_valid_i) begin
        vcount_q <= cfg_data_i;
      end
      ecnt_q     <= ecnt_d;
      drop_q     <= drop_d;
      eidx_q     <= eidx_d;
      idx_q      <= idx_d;
      rpos_q     <= rpos_d;
      wpos_q     <= wpos_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    tgt_q      <= tgt_d;
    hold_vtx_q <= hold_vtx_d;
    out_vtx_q  <= out_vtx_d;
    out_vv_q   <= out_vv_d;
    out_cyc_q  <= out_cyc_d;
    out_drp_q  <= out_drp_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o    = out_vld_q;
  assign vertex_out_o   = out_vtx_q;
  assign vertex_valid_o = out_vv_q;
  assign cycle_found_o  = out_cyc_q;
  assign edge_dropped_o = out_drp_q;
  assign last_result_o  = out_last_q;

  // The queue is never read past what has been written.
  a_queue_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rpos_q <= wpos_q) else $error("ready queue read passed write");

  // Each vertex is queued at most once, so the queue never overflows.
  a_queue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wpos_q <= CW'(tks_pkg::MaxVertices)) else $error("ready queue overflow");

  // Finishing a sort always presents a final result.
  a_fin_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && can_push) |=> (out_vld_q && out_last_q))
    else $error("sort finished without a final result");

endmodule
